// File: rtl/biq_pkg.sv
package biq_pkg;

  // Coefficient word and delay register widths are fixed by the format.
  localparam int COEF_BITS  = 16;
  localparam int DELAY_BITS = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = $clog2(COEF_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_COEF_B0 = 3'd1,
    REG_COEF_B1 = 3'd2,
    REG_COEF_B2 = 3'd3,
    REG_COEF_A1 = 3'd4,
    REG_COEF_A2 = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B,
    ST_ROUND,
    ST_MUL_A,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  // One coefficient bit of each multiplier, least significant first.
  typedef struct packed {
    logic b0;
    logic b1;
    logic b2;
    logic a1;
    logic a2;
  } coef_bits_t;

  typedef struct packed {
    logic       idle;
    logic       load;
    logic       step_b;
    logic       step_a;
    logic       last;
    logic       round;
    logic       commit;
    logic       capture;
    coef_bits_t bits;
  } lane_ctrl_t;

endpackage

// File: rtl/biq_ctrl.sv
module biq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  enable,
  input  biq_pkg::coef_set_t    coef,
  input  logic                  out_free,
  output biq_pkg::lane_ctrl_t   ctrl
);
  import biq_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [COEF_BITS-1:0]   b0_sh_r, b1_sh_r, b2_sh_r, a1_sh_r, a2_sh_r;
  logic                   last;
  logic                   stepping;

  assign last     = (cnt_r == CNT_W'(COEF_BITS - 1));
  assign stepping = (state_r == ST_MUL_B) || (state_r == ST_MUL_A);
  assign cnt_nxt  = (stepping && !last) ? cnt_r + CNT_W'(1) : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = enable ? ST_MUL_B : ST_DONE;
        end
      end
      ST_MUL_B: begin
        if (last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_MUL_A;
      ST_MUL_A: begin
        if (last) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.idle    = (state_r == ST_IDLE);
    ctrl.load    = (state_r == ST_IDLE) && start;
    ctrl.step_b  = (state_r == ST_MUL_B);
    ctrl.step_a  = (state_r == ST_MUL_A);
    ctrl.last    = last;
    ctrl.round   = (state_r == ST_ROUND);
    ctrl.commit  = (state_r == ST_SAT);
    ctrl.capture = (state_r == ST_DONE) && out_free;
    ctrl.bits.b0 = b0_sh_r[0];
    ctrl.bits.b1 = b1_sh_r[0];
    ctrl.bits.b2 = b2_sh_r[0];
    ctrl.bits.a1 = a1_sh_r[0];
    ctrl.bits.a2 = a2_sh_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Coefficients shift out one bit per cycle, feed-forward set first.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      b0_sh_r <= coef.b0;
      b1_sh_r <= coef.b1;
      b2_sh_r <= coef.b2;
      a1_sh_r <= coef.a1;
      a2_sh_r <= coef.a2;
    end else if (state_r == ST_MUL_B) begin
      b0_sh_r <= b0_sh_r >> 1;
      b1_sh_r <= b1_sh_r >> 1;
      b2_sh_r <= b2_sh_r >> 1;
    end else if (state_r == ST_MUL_A) begin
      a1_sh_r <= a1_sh_r >> 1;
      a2_sh_r <= a2_sh_r >> 1;
    end
  end

endmodule

// File: rtl/biq_lane.sv
module biq_lane #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  biq_pkg::lane_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS-1:0] y
);
  import biq_pkg::*;

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = ((PROD_W > DELAY_BITS) ? PROD_W : DELAY_BITS) + 2;

  logic signed [ACC_W-1:0]       mcand_r, mcand_nxt;
  logic signed [ACC_W-1:0]       acc0_r, acc0_nxt;
  logic signed [ACC_W-1:0]       acc1_r, acc1_nxt;
  logic signed [ACC_W-1:0]       acc2_r, acc2_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r, y_nxt;
  logic signed [DELAY_BITS-1:0]  d1_r, d1_nxt;
  logic signed [DELAY_BITS-1:0]  d2_r, d2_nxt;

  logic signed [ACC_W-1:0]       shifted;
  logic [ACC_W-SAMPLE_BITS:0]    y_top;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [DELAY_BITS-1:0]  d1_sat, d2_sat;

  // Add one shifted partial product, optionally negated through the carry in.
  function automatic logic signed [ACC_W-1:0] add_pp(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ACC_W-1:0] m,
    input logic                    bit_on,
    input logic                    neg
  );
    logic [ACC_W-1:0] term;
    term   = (m ^ {ACC_W{neg}}) & {ACC_W{bit_on}};
    add_pp = acc + term + ACC_W'(bit_on & neg);
  endfunction

  function automatic logic signed [DELAY_BITS-1:0] sat_delay(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-DELAY_BITS:0] top;
    top = v[ACC_W-1:DELAY_BITS-1];
    if ((&top) || !(|top)) begin
      sat_delay = v[DELAY_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      sat_delay = {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      sat_delay = {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
  endfunction

  assign shifted = acc0_r >>> COEF_FRAC_BITS;
  assign y_top   = shifted[ACC_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_sat = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign d1_sat = sat_delay(acc1_r);
  assign d2_sat = sat_delay(acc2_r);

  always_comb begin
    mcand_nxt = mcand_r;
    acc0_nxt  = acc0_r;
    acc1_nxt  = acc1_r;
    acc2_nxt  = acc2_r;
    y_nxt     = y_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    if (ctrl.load) begin
      // The rounding half is folded into the output accumulator up front.
      mcand_nxt = ACC_W'(x);
      acc0_nxt  = ACC_W'(d1_r) + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
      acc1_nxt  = ACC_W'(d2_r);
      acc2_nxt  = '0;
      y_nxt     = x;
    end else if (ctrl.step_b) begin
      // The coefficient sign bit has negative weight.
      mcand_nxt = mcand_r <<< 1;
      acc0_nxt  = add_pp(acc0_r, mcand_r, ctrl.bits.b0, ctrl.last);
      acc1_nxt  = add_pp(acc1_r, mcand_r, ctrl.bits.b1, ctrl.last);
      acc2_nxt  = add_pp(acc2_r, mcand_r, ctrl.bits.b2, ctrl.last);
    end else if (ctrl.round) begin
      y_nxt     = y_sat;
      mcand_nxt = ACC_W'(y_sat);
    end else if (ctrl.step_a) begin
      // Feedback terms are subtracted, so the sign handling flips.
      mcand_nxt = mcand_r <<< 1;
      acc1_nxt  = add_pp(acc1_r, mcand_r, ctrl.bits.a1, !ctrl.last);
      acc2_nxt  = add_pp(acc2_r, mcand_r, ctrl.bits.a2, !ctrl.last);
    end else if (ctrl.commit) begin
      d1_nxt = d1_sat;
      d2_nxt = d2_sat;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    acc0_r  <= acc0_nxt;
    acc1_r  <= acc1_nxt;
    acc2_r  <= acc2_nxt;
    y_r     <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  assign y = y_r;

endmodule

// File: rtl/stereo_biquad_filter.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_tvalid/in_tready   in_tdata: left_in, right_in
// out_     output     out_tvalid/out_tready out_tdata: left_out, right_out
// cfg_     input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// With filtering enabled an item passes from acceptance to a loaded output
// register through one load, the bit-serial feed-forward products, one
// rounding step, the bit-serial feedback products, one delay update
// and one output capture. The 16-bit coefficient word, consumed one bit per
// cycle, sets both multiply phases. Disabled, an item goes straight to capture.
// Reset (rst_n, synchronous, active low) loads the default coefficients, clears
// enable and zeroes all four delay registers. A stalled output holds the
// finished item while the next item is taken in and processed.
module stereo_biquad_filter #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [TDATA_W-1:0]                in_tdata,   // left_in, right_in, zero pad
  // Result items.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [TDATA_W-1:0]                out_tdata,  // left_out, right_out, zero pad
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [biq_pkg::COEF_BITS-1:0]     cfg_data
);
  import biq_pkg::*;

  logic                          enable_r;
  coef_set_t                     coef_r;
  lane_ctrl_t                    ctrl;
  logic                          in_fire;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] left_x, right_x;
  logic signed [SAMPLE_BITS-1:0] left_y, right_y;
  logic                          out_valid_r;
  logic [2*SAMPLE_BITS-1:0]      out_pair_r;

  assign cfg_ready = 1'b1;
  assign in_tready = ctrl.idle;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign left_x  = in_tdata[SAMPLE_BITS-1:0];
  assign right_x = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // Register writes must arrive only while the filter is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      coef_r.b0 <= COEF_BITS'(1 << COEF_FRAC_BITS);
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:  enable_r  <= cfg_data[0];
        REG_COEF_B0: coef_r.b0 <= cfg_data;
        REG_COEF_B1: coef_r.b1 <= cfg_data;
        REG_COEF_B2: coef_r.b2 <= cfg_data;
        REG_COEF_A1: coef_r.a1 <= cfg_data;
        REG_COEF_A2: coef_r.a2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The sequencer is shared; both channels step in lockstep.
  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .enable   (enable_r),
    .coef     (coef_r),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  biq_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .x     (left_x),
    .y     (left_y)
  );

  biq_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .x     (right_x),
    .y     (right_y)
  );

  // Output register decouples the result side from the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.capture) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      out_pair_r <= {right_y, left_y};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_pair_r);

endmodule

// File: tb/stereo_biquad_filter_tb.sv
`timescale 1ns / 1ps

module stereo_biquad_filter_tb;
  import biq_pkg::*;

  localparam int SAMPLE_BITS      = 16;
  localparam int FRAC_BITS        = 14;
  localparam int TDATA_W          = 32;
  // Long enough for an enabled item to pass through the block and the output register.
  localparam int LATENCY_CYCLES   = 40;
  localparam int MAX_IDLE         = 18;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES    = 12;
  localparam int FRAMES_PER_PHASE = 94;
  localparam int MAX_REPORTS      = 40;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [COEF_BITS-1:0] COEF_MAX   = 16'h7FFF;
  localparam logic [COEF_BITS-1:0] COEF_MIN   = 16'h8000;
  localparam logic [COEF_BITS-1:0] COEF_HALF  = 16'h2000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  // Same layout as tdata: left in the low half, right in the high half.
  typedef struct packed {
    sample_t right;
    sample_t left;
  } frame_t;

  typedef enum logic [0:0] {ROW_WRITE, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [COEF_BITS-1:0]   wdata;
    frame_t                 frame;
    bit                     typed;
    frame_t                 want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0] cfg_data = '0;

  // Filter model state, starting from the reset values.
  bit     filter_on = 1'b0;
  longint coef_b0 = 16384;
  longint coef_b1 = 0;
  longint coef_b2 = 0;
  longint coef_a1 = 0;
  longint coef_a2 = 0;
  longint delay_one [2] = '{0, 0};
  longint delay_two [2] = '{0, 0};

  frame_t    pending_frames [$];
  plan_row_t plan [$];
  int        n_errors = 0;
  int        long_hold = 0;
  bit        snd_idle = 1'b1;
  bit        rcv_idle = 1'b1;

  stereo_biquad_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One transposed direct form II section; the feedback uses the saturated output.
  function automatic sample_t run_lane(input int ch, input sample_t x_in);
    longint x;
    longint acc;
    longint y;
    x   = x_in;
    acc = coef_b0 * x + delay_one[ch];
    y   = saturate((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS, SAMPLE_BITS);
    delay_one[ch] = saturate(coef_b1 * x - coef_a1 * y + delay_two[ch], DELAY_BITS);
    delay_two[ch] = saturate(coef_b2 * x - coef_a2 * y, DELAY_BITS);
    return sample_t'(y);
  endfunction

  // Disabled frames pass straight through and leave the delays alone.
  function automatic frame_t filter_frame(input frame_t f);
    frame_t r;
    r = f;
    if (filter_on) begin
      r.left  = run_lane(0, f.left);
      r.right = run_lane(1, f.right);
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COEF_BITS-1:0] data);
    case (idx)
      REG_ENABLE:  filter_on = data[0];
      REG_COEF_B0: coef_b0 = longint'($signed(data));
      REG_COEF_B1: coef_b1 = longint'($signed(data));
      REG_COEF_B2: coef_b2 = longint'($signed(data));
      REG_COEF_A1: coef_a1 = longint'($signed(data));
      REG_COEF_A2: coef_a2 = longint'($signed(data));
      default: ;
    endcase
  endfunction

  function automatic sample_t rail_sample();
    case ($urandom_range(0, 3))
      0:       return sample_t'(COEF_MAX);
      1:       return sample_t'(COEF_MIN);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly full-range noise, with some rail values and some quiet passages.
  function automatic frame_t random_frame();
    frame_t f;
    f = frame_t'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        f.left  = rail_sample();
        f.right = rail_sample();
      end
      1, 2: begin
        f.left  = $signed(f.left) >>> 7;
        f.right = $signed(f.right) >>> 7;
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [COEF_BITS-1:0] random_coef(input bit gentle);
    case ($urandom_range(0, 7))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      default: begin
        if (gentle) return COEF_BITS'($urandom_range(0, 16383) - 8192);
        return COEF_BITS'($urandom);
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    if (n_errors < MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_BITS-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, wdata: data, frame: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  task automatic plan_frame(input int l, input int r);
    plan_row_t row;
    row = '{kind: ROW_FRAME, idx: '0, wdata: '0, frame: {sample_t'(r), sample_t'(l)},
            typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  task automatic plan_check(input int l, input int r, input int wl, input int wr);
    plan_row_t row;
    row = '{kind: ROW_FRAME, idx: '0, wdata: '0, frame: {sample_t'(r), sample_t'(l)},
            typed: 1'b1, want: {sample_t'(wr), sample_t'(wl)}};
    plan.push_back(row);
  endtask

  // Entered and left at a falling edge. Valid stays high into the next item when
  // no gap is drawn, so it is never lowered and raised in the same step.
  task automatic send_frame(input frame_t f, input bit typed, input frame_t want);
    int     gap;
    frame_t predicted;
    gap = snd_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    do @(posedge clk); while (!in_tready);
    predicted = filter_frame(f);
    pending_frames.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Valid is left high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
  endtask

  // Registers only change once the block has gone quiet.
  task automatic settle();
    wait_drained();
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  // Result side: draw a stall, then take one item and compare it with the oldest
  // expectation. A long hold requested by the stimulus replaces the drawn stall.
  initial begin
    int     stall;
    frame_t got;
    frame_t want;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = 0;
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end else if (rcv_idle) begin
        stall = int'($urandom_range(0, MAX_IDLE));
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = frame_t'(out_tdata);
      if (pending_frames.size() == 0) begin
        flag_error($sformatf("unexpected item %h", got));
      end else begin
        want = pending_frames.pop_front();
        if (got.left !== want.left)
          flag_error($sformatf("left_out %0d, expected %0d", got.left, want.left));
        if (got.right !== want.right)
          flag_error($sformatf("right_out %0d, expected %0d", got.right, want.right));
      end
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    bit       writing;
    bit       gentle;
    cfg_reg_t coef_regs [5];
    coef_regs = '{REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_A1, REG_COEF_A2};

    // Just out of reset the block is disabled, so frames come back unchanged.
    plan_check(32767, -32768, 32767, -32768);
    plan_check(0, -1, 0, -1);
    plan_check(-32768, 32767, -32768, 32767);
    // Unmapped indexes and the upper bits of an enable write are ignored.
    plan_write(REG_UNMAPPED_HI, 16'h0001);
    plan_write(REG_UNMAPPED_LO, 16'hFFFF);
    plan_check(1234, -4321, 1234, -4321);
    plan_write(REG_ENABLE, 16'hFFFE);
    plan_check(21845, -21846, 21845, -21846);
    // Enabled with the reset coefficients the section is a unity gain.
    plan_write(REG_ENABLE, 16'h0001);
    plan_check(32767, -32768, 32767, -32768);
    plan_check(-1, 1, -1, 1);
    // A gain near two drives both rails into saturation.
    plan_write(REG_COEF_B0, COEF_MAX);
    plan_check(32767, -32768, 32767, -32768);
    plan_write(REG_COEF_B0, COEF_MIN);
    plan_check(-32768, 32767, 32767, -32768);
    // Half gain: exact halves round toward plus infinity.
    plan_write(REG_COEF_B0, COEF_HALF);
    plan_check(1, -1, 1, 0);
    plan_check(3, -3, 2, -1);
    plan_check(32767, -32768, 16384, -16384);
    // Every coefficient at a rail, with full-scale input, loads the delays hard.
    plan_write(REG_COEF_B0, COEF_MAX);
    plan_write(REG_COEF_B1, COEF_MAX);
    plan_write(REG_COEF_B2, COEF_MAX);
    plan_write(REG_COEF_A1, COEF_MIN);
    plan_write(REG_COEF_A2, COEF_MIN);
    plan_frame(32767, 32767);
    plan_frame(-32768, 32767);
    plan_frame(32767, -32768);
    plan_frame(-32768, -32768);
    // Disabling passes samples through and must hold the loaded delays.
    plan_write(REG_ENABLE, 16'h0000);
    plan_check(100, -100, 100, -100);
    plan_check(-32768, 32767, -32768, 32767);
    plan_write(REG_ENABLE, 16'h0001);
    plan_frame(0, 0);
    plan_frame(0, 0);
    plan_write(REG_COEF_B1, COEF_MIN);
    plan_write(REG_COEF_B2, COEF_MIN);
    plan_write(REG_COEF_A1, COEF_MAX);
    plan_write(REG_COEF_A2, COEF_MAX);
    plan_frame(32767, -32768);
    plan_frame(-32768, 32767);
    plan_frame(0, 0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) settle();
        writing = 1'b1;
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        if (writing) cfg_valid <= 1'b0;
        writing = 1'b0;
        send_frame(plan[i].frame, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each with its own coefficient set and idling pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      snd_idle = (p % 4 != 3) && ($urandom_range(0, 3) != 0);
      rcv_idle = (p % 4 != 3) && ($urandom_range(0, 3) != 0);
      case (p)
        0: begin
          foreach (coef_regs[k]) write_reg(coef_regs[k], COEF_MAX);
          write_reg(REG_ENABLE, 16'h0001);
        end
        1: begin
          foreach (coef_regs[k]) write_reg(coef_regs[k], COEF_MIN);
          write_reg(REG_ENABLE, 16'h0001);
        end
        2: begin
          // Disabled phase: delays from the phase before must survive it.
          foreach (coef_regs[k]) write_reg(coef_regs[k], random_coef(1'b0));
          write_reg(REG_ENABLE, {COEF_BITS'($urandom) & ~COEF_BITS'(1)});
        end
        default: begin
          gentle = $urandom_range(0, 2) != 0;
          foreach (coef_regs[k]) begin
            if ($urandom_range(0, 3) != 0) write_reg(coef_regs[k], random_coef(gentle));
          end
          if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED_HI, COEF_BITS'($urandom));
          write_reg(REG_ENABLE, {COEF_BITS'($urandom) & ~COEF_BITS'(1)} |
                                COEF_BITS'($urandom_range(0, 5) != 0));
        end
      endcase
      cfg_valid <= 1'b0;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        // The receiver stops for a long stretch while frames keep coming, so the
        // block fills up and has to hold off its input.
        if (p == 5 && n == 10) long_hold = LONG_HOLD_CYCLES;
        // The sender stops until every outstanding result is back.
        if (p == 7 && n == 50) wait_drained();
        send_frame(random_frame(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (LATENCY_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
